@@ rtl/core/olie_pkg.sv @@
package olie_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int POS_W    = 8;
  localparam int FUNC_W   = 2;
  localparam int COUNT_W  = 7;
  localparam int FILL_W   = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CMP_W    = (FILL_W > POS_W) ? FILL_W : POS_W;

  typedef enum logic [FUNC_W-1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
  } cell_ctl_t;

endpackage

@@ rtl/core/olie_if.sv @@
interface olie_req_if import olie_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [POS_W-1:0]  position;
  logic signed [DATA_W-1:0] item_value;

  modport source (output valid, func, position, item_value, input ready);
  modport sink (input valid, func, position, item_value, output ready);
endinterface

interface olie_rsp_if import olie_pkg::*; ;
  logic                     valid;
  logic                     ready;
  logic                     ok;
  logic signed [DATA_W-1:0] read_data;
  logic [COUNT_W-1:0]       count;

  modport source (output valid, ok, read_data, count, input ready);
  modport sink (input valid, ok, read_data, count, output ready);
endinterface

@@ rtl/core/ordered_list_insert_erase.sv @@
// channel | dir | payload                         | transfer
// req     | in  | func, position, item_value      | valid && ready
// rsp     | out | ok, read_data, count            | valid && ready
//
// one request per cycle unless a result waits on rsp; the result is registered, valid in the cycle after its transfer
// every cell of the row shifts, loads or holds in the cycle of the transfer
// rst clears the length and the result valid; cell contents are left as they are
// req.ready is low only while a result waits and rsp.ready is low
module ordered_list_insert_erase import olie_pkg::*; (
  input logic         clk,
  input logic         rst,
  olie_req_if.sink    req,
  olie_rsp_if.source  rsp
);

  logic [FILL_W-1:0]        fill;
  logic [FILL_W-1:0]        fill_next;
  logic                     out_valid;
  logic                     out_ok;
  logic signed [DATA_W-1:0] out_data;
  logic [COUNT_W-1:0]       out_count;

  logic                     take;
  logic                     neg;
  logic [CMP_W-1:0]         pos_u;
  logic [CMP_W-1:0]         fill_c;
  logic                     ins_ok;
  logic                     erase_ok;
  logic                     read_ok;
  logic signed [DATA_W-1:0] q [CAPACITY];

  assign req.ready = !out_valid || rsp.ready;
  assign take      = req.valid && req.ready;
  assign neg       = req.position[POS_W-1];
  assign pos_u     = CMP_W'(req.position[POS_W-2:0]);
  assign fill_c    = CMP_W'(fill);

  assign ins_ok   = (req.func == OP_INSERT) && !neg && (fill < FILL_W'(CAPACITY))
                    && (pos_u <= fill_c);
  assign erase_ok = (req.func == OP_ERASE) && !neg && (pos_u < fill_c);
  assign read_ok  = (req.func == OP_READ) && !neg && (pos_u < fill_c);

  always_comb begin
    fill_next = fill;
    if (ins_ok) begin
      fill_next = fill + FILL_W'(1);
    end else if (erase_ok) begin
      fill_next = fill - FILL_W'(1);
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t                ctl;
    logic signed [DATA_W-1:0] left;
    logic signed [DATA_W-1:0] right;

    assign ctl.load       = take && ins_ok && (CMP_W'(i) == pos_u);
    assign ctl.take_left  = take && ins_ok && (CMP_W'(i) > pos_u);
    assign ctl.take_right = take && erase_ok && (CMP_W'(i) >= pos_u);

    if (i == 0) begin : g_first
      assign left = req.item_value;
    end else begin : g_mid_l
      assign left = q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right = q[i];
    end else begin : g_mid_r
      assign right = q[i+1];
    end

    olie_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .value (req.item_value),
      .left  (left),
      .right (right),
      .q     (q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        fill      <= fill_next;
        out_valid <= 1'b1;
        out_ok    <= ins_ok || erase_ok || read_ok;
        out_data  <= read_ok ? q[pos_u[IDX_W-1:0]] : '0;
        out_count <= COUNT_W'(fill_next);
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.ok        = out_ok;
  assign rsp.read_data = out_data;
  assign rsp.count     = out_count;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(CAPACITY))
    else $error("length beyond capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    take && ins_ok |=> fill == $past(fill) + FILL_W'(1))
    else $error("insert did not grow the list");

  a_erase_shrinks: assert property (@(posedge clk) disable iff (rst)
    take && erase_ok |=> fill == $past(fill) - FILL_W'(1))
    else $error("erase did not shrink the list");

  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    take && !ins_ok && !erase_ok |=> $stable(fill))
    else $error("rejected request changed the list");

  a_reject_flag: assert property (@(posedge clk) disable iff (rst)
    take && !ins_ok && !erase_ok && !read_ok |=> !out_ok)
    else $error("rejected request reported success");

endmodule

@@ rtl/core/olie_cell.sv @@
module olie_cell import olie_pkg::*; (
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] value,
  input  logic signed [DATA_W-1:0] left,
  input  logic signed [DATA_W-1:0] right,
  output logic signed [DATA_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q <= value;
    end else if (ctl.take_left) begin
      q <= left;
    end else if (ctl.take_right) begin
      q <= right;
    end
  end

endmodule
